@@ hdl/mmch_pkg.sv @@
// Shared types, constants and helpers for the multiway merge capture histogram.
// Used by mmch_lane, mmch_hist and multiway_merge_capture_histogram_top.
// Depends on nothing.
package mmch_pkg;

   localparam int MAX_LANES       = 4;
   localparam int KEY_BITS        = 64;
   localparam int FIELD_KEY_BITS  = 64;
   localparam int COUNT_BITS      = 48;
   localparam int HIST_DEPTH      = 1 << MAX_LANES;
   localparam int SRC_COUNT_BITS  = 3;
   localparam int MIN_SOURCES     = 2;
   localparam logic [SRC_COUNT_BITS-1:0] SRC_COUNT_RESET = SRC_COUNT_BITS'(MIN_SOURCES);

   typedef enum logic {
      OP_STEP = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    operation;
      logic [FIELD_KEY_BITS-1:0] head_key_0;
      logic [FIELD_KEY_BITS-1:0] head_key_1;
      logic [FIELD_KEY_BITS-1:0] head_key_2;
      logic [FIELD_KEY_BITS-1:0] head_key_3;
      logic [MAX_LANES-1:0]      live_mask;
      logic [MAX_LANES-1:0]      read_index;
   } req_type;

   typedef struct packed {
      logic [MAX_LANES-1:0]  advance_mask;
      logic [COUNT_BITS-1:0] count_value;
      logic                  all_ended;
   } rsp_type;

   // Control that travels with a transaction into the histogram stage.
   typedef struct packed {
      op_type               operation;
      logic [MAX_LANES-1:0] live;
      logic [MAX_LANES-1:0] read_index;
   } ctl_type;

   // Clamp the source count into range and expand it to a mask of lanes in use.
   function automatic logic [MAX_LANES-1:0] used_mask(input logic [SRC_COUNT_BITS-1:0] sc);
      int n;
      logic [MAX_LANES-1:0] m;
      n = int'(sc);
      if (n < MIN_SOURCES) n = MIN_SOURCES;
      if (n > MAX_LANES) n = MAX_LANES;
      for (int i = 0; i < MAX_LANES; i++) begin
         m[i] = (i < n);
      end
      return m;
   endfunction

endpackage

@@ hdl/multiway_merge_capture_histogram_top.sv @@
// Top level of the multiway merge capture histogram: input stage, lanes,
// histogram stage and result register. Depends on mmch_pkg, mmch_lane, mmch_hist.
//
// One merge step or histogram read per transaction, one transaction per clock
// sustained while rsp_stall is low. A transaction is captured into an input
// register; in the next cycle each lane compares its head key against the
// other live lanes, the winning lanes form the advance mask, and that mask's
// 48-bit saturating count is read, incremented and written back in the same
// cycle as the transaction moves into the result register. rsp_valid rises
// when the transaction moves from the input register into the result register.
// Because a histogram entry's read-modify-write completes as the transaction
// leaves the input register, back-to-back steps on the same mask see each other's
// updates with no bubble. req_stall rises only when both the input register
// and the result register are full and rsp_stall is high. source_count is
// clamped to 2..4 and lanes at or above it are ignored; write csr_ only while
// no transaction is in flight. Reset clears all sixteen histogram entries at once.
module multiway_merge_capture_histogram_top #(
   parameter int KEY_BITS = mmch_pkg::KEY_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mmch_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mmch_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_en,
   input  logic [mmch_pkg::SRC_COUNT_BITS-1:0]  csr_write_data
);

   logic                                   s1_valid_ff;
   logic                                   s1_valid_in;
   mmch_pkg::req_type                      s1_req_ff;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   mmch_pkg::rsp_type                      rsp_data_ff;
   logic [mmch_pkg::SRC_COUNT_BITS-1:0]    source_count_ff;

   logic                                   out_free;
   logic                                   s1_move;
   logic                                   req_fire;
   logic [mmch_pkg::MAX_LANES-1:0]         lanes_used;
   logic [mmch_pkg::MAX_LANES-1:0]         live_eff;
   logic [mmch_pkg::MAX_LANES-1:0]         win_mask;
   logic [mmch_pkg::MAX_LANES-1:0][mmch_pkg::FIELD_KEY_BITS-1:0] keys;
   mmch_pkg::ctl_type                      ctl;
   mmch_pkg::rsp_type                      hist_result;

   // Handshake: advance the input stage whenever the result register can take it.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Drop live bits of lanes beyond the configured source count.
   assign lanes_used = mmch_pkg::used_mask(source_count_ff);
   assign live_eff   = s1_req_ff.live_mask & lanes_used;

   assign keys[0] = s1_req_ff.head_key_0;
   assign keys[1] = s1_req_ff.head_key_1;
   assign keys[2] = s1_req_ff.head_key_2;
   assign keys[3] = s1_req_ff.head_key_3;

   assign ctl.operation  = s1_req_ff.operation;
   assign ctl.live       = live_eff;
   assign ctl.read_index = s1_req_ff.read_index;

   for (genvar g = 0; g < mmch_pkg::MAX_LANES; g++) begin : g_lane
      mmch_lane #(
         .LANE     (g),
         .KEY_BITS (KEY_BITS)
      ) u_lane (
         .keys (keys),
         .live (live_eff),
         .win  (win_mask[g])
      );
   end

   // Commit the histogram update exactly once, as the transaction leaves stage 1.
   mmch_hist u_hist (
      .clock     (clock),
      .reset     (reset),
      .update_en (s1_move),
      .ctl       (ctl),
      .win_mask  (win_mask),
      .result    (hist_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         source_count_ff <= mmch_pkg::SRC_COUNT_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            source_count_ff <= csr_write_data;
         end
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= hist_result;
      end
   end

`ifndef SYNTHESIS
   // An ended step reports no mask and no count.
   a_ended_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.all_ended |->
         rsp_data_ff.advance_mask == '0 && rsp_data_ff.count_value == '0)
      else $error("ended step carried a mask or count");

   // The advance mask never names a lane outside the configured source count.
   a_mask_in_use : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.advance_mask & ~lanes_used) == '0)
      else $error("advance mask names an unused lane");

   // Input stalls only while stage 1 holds a transaction behind a full output.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled without backpressure");

   // A transaction leaving stage 1 shows up in the result register next cycle.
   a_move_lands : assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("stage 1 transaction lost");
`endif

endmodule

@@ hdl/mmch_lane.sv @@
// One merge lane: decides whether its source holds the smallest live key.
// Compares its own key against every other live lane in parallel.
// Depends on mmch_pkg.
module mmch_lane #(
   parameter int LANE     = 0,
   parameter int KEY_BITS = mmch_pkg::KEY_BITS
) (
   input  logic [mmch_pkg::MAX_LANES-1:0][mmch_pkg::FIELD_KEY_BITS-1:0] keys,
   input  logic [mmch_pkg::MAX_LANES-1:0]                               live,
   output logic                                                         win
);

   logic [KEY_BITS-1:0] own_key;

   // Win when live and no other live lane holds a strictly smaller key;
   // every lane tied at the minimum wins.
   always_comb begin
      own_key = keys[LANE][KEY_BITS-1:0];
      win     = live[LANE];
      for (int j = 0; j < mmch_pkg::MAX_LANES; j++) begin
         if (j != LANE && live[j] && (keys[j][KEY_BITS-1:0] < own_key)) begin
            win = 1'b0;
         end
      end
   end

endmodule

@@ hdl/mmch_hist.sv @@
// Merging stage and histogram: combines the lane wins into a membership mask,
// bumps that mask's saturating count, flags a step with no live lane as ended, or returns an entry on a read.
// Depends on mmch_pkg.
module mmch_hist (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update_en,
   input  mmch_pkg::ctl_type             ctl,
   input  logic [mmch_pkg::MAX_LANES-1:0] win_mask,
   output mmch_pkg::rsp_type             result
);

   logic [mmch_pkg::COUNT_BITS-1:0] counts_ff [mmch_pkg::HIST_DEPTH];
   logic [mmch_pkg::COUNT_BITS-1:0] count_cur;
   logic [mmch_pkg::COUNT_BITS-1:0] count_in;
   logic [mmch_pkg::MAX_LANES-1:0]  addr;
   logic                            is_step;
   logic                            ended;

   always_comb begin
      is_step   = (ctl.operation == mmch_pkg::OP_STEP);
      ended     = (ctl.live == '0);
      addr      = is_step ? win_mask : ctl.read_index;
      count_cur = counts_ff[addr];
      // hold at full scale
      count_in  = (&count_cur) ? count_cur : count_cur + 1'b1;

      if (!is_step) begin
         result.advance_mask = '0;
         result.count_value  = count_cur;
         result.all_ended    = 1'b0;
      end else if (ended) begin
         result.advance_mask = '0;
         result.count_value  = '0;
         result.all_ended    = 1'b1;
      end else begin
         result.advance_mask = win_mask;
         result.count_value  = count_in;
         result.all_ended    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mmch_pkg::HIST_DEPTH; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (update_en && is_step && !ended) begin
         counts_ff[addr] <= count_in;
      end
   end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for multiway_merge_capture_histogram_top.
// Depends on mmch_pkg for the transaction types and on the top level of the block.
// Checks directed table rows and random merge runs against a predictor of the histogram.
module tb_top;

   localparam int MAX_LANES      = mmch_pkg::MAX_LANES;
   localparam int FIELD_KEY_BITS = mmch_pkg::FIELD_KEY_BITS;
   localparam int COUNT_BITS     = mmch_pkg::COUNT_BITS;
   localparam int HIST_DEPTH     = mmch_pkg::HIST_DEPTH;
   localparam int SRC_COUNT_BITS = mmch_pkg::SRC_COUNT_BITS;
   localparam int MIN_SOURCES    = mmch_pkg::MIN_SOURCES;

   // Directed table row: either a source count write or one request transaction.
   // A row with a typed answer is checked against it instead of the predictor.
   typedef struct {
      bit                        is_csr;
      logic [SRC_COUNT_BITS-1:0] csr_val;
      mmch_pkg::req_type         item;
      bit                        typed;
      mmch_pkg::rsp_type         want;
   } stim_row_type;

   localparam logic [FIELD_KEY_BITS-1:0] KEY_MAX   = '1;
   localparam logic [FIELD_KEY_BITS-1:0] KEY_APPLE = 64'h6170706C65000000;
   localparam logic [FIELD_KEY_BITS-1:0] KEY_APPLES = 64'h6170706C65730000;
   localparam mmch_pkg::rsp_type ZERO_COUNT =
      '{advance_mask: '0, count_value: '0, all_ended: 1'b0};
   localparam mmch_pkg::rsp_type NONE_LIVE  =
      '{advance_mask: '0, count_value: '0, all_ended: 1'b1};
   localparam int PHASE_ITEMS = 90;
   localparam int POOL_DEPTH  = 12;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   mmch_pkg::req_type         req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   mmch_pkg::rsp_type         rsp_data;
   logic                      csr_write_en = 1'b0;
   logic [SRC_COUNT_BITS-1:0] csr_write_data = '0;

   // Predictor state: histogram of membership masks and the source count register.
   logic [COUNT_BITS-1:0]     mask_count_model [HIST_DEPTH];
   logic [SRC_COUNT_BITS-1:0] src_count_model;
   mmch_pkg::rsp_type         pending_rsp_q [$];
   stim_row_type              directed_rows [$];

   int fail_count     = 0;
   int step_count     = 0;
   int ended_count    = 0;
   int read_count     = 0;
   int csr_writes     = 0;
   int burst_left     = 0;
   int stall_mode     = 0;
   int stall_left     = 0;

   multiway_merge_capture_histogram_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp the programmed source count into the legal lane range.
   function automatic int lanes_in_use();
      int n;
      n = int'(src_count_model);
      if (n < MIN_SOURCES) n = MIN_SOURCES;
      if (n > MAX_LANES) n = MAX_LANES;
      return n;
   endfunction

   // Work out the response to one transaction and update the histogram.
   // KEY_BITS equals the field width here, so keys compare in full.
   function automatic mmch_pkg::rsp_type predict_merge(input mmch_pkg::req_type it);
      int                        n;
      logic [MAX_LANES-1:0]      live;
      logic [MAX_LANES-1:0]      sel;
      logic [FIELD_KEY_BITS-1:0] heads [MAX_LANES];
      logic [FIELD_KEY_BITS-1:0] best;
      bit                        found;
      mmch_pkg::rsp_type         r;
      r = '0;
      n = lanes_in_use();
      heads[0] = it.head_key_0;
      heads[1] = it.head_key_1;
      heads[2] = it.head_key_2;
      heads[3] = it.head_key_3;
      if (it.operation == mmch_pkg::OP_READ) begin
         r.count_value = mask_count_model[it.read_index];
         return r;
      end
      // Drop live bits of lanes beyond the source count.
      live = '0;
      for (int i = 0; i < n; i++) live[i] = it.live_mask[i];
      if (live == '0) begin
         r.all_ended = 1'b1;
         return r;
      end
      found = 1'b0;
      best  = '0;
      sel   = '0;
      for (int i = 0; i < n; i++) begin
         if (live[i] && (!found || heads[i] < best)) begin
            best  = heads[i];
            found = 1'b1;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (live[i] && heads[i] == best) sel[i] = 1'b1;
      end
      // Hold the entry at full scale once it saturates.
      if (mask_count_model[sel] != '1) mask_count_model[sel] = mask_count_model[sel] + 1'b1;
      r.advance_mask = sel;
      r.count_value  = mask_count_model[sel];
      return r;
   endfunction

   function automatic logic [FIELD_KEY_BITS-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   function automatic stim_row_type mk_step(input logic [FIELD_KEY_BITS-1:0] k0, k1, k2, k3,
                                            input logic [MAX_LANES-1:0] live);
      stim_row_type r;
      r = '{is_csr: 1'b0, csr_val: '0, item: '0, typed: 1'b0, want: '0};
      r.item.operation  = mmch_pkg::OP_STEP;
      r.item.head_key_0 = k0;
      r.item.head_key_1 = k1;
      r.item.head_key_2 = k2;
      r.item.head_key_3 = k3;
      r.item.live_mask  = live;
      r.item.read_index = MAX_LANES'($urandom);
      return r;
   endfunction

   function automatic stim_row_type mk_read(input logic [MAX_LANES-1:0] idx);
      stim_row_type r;
      r = mk_step(random_key(), random_key(), random_key(), random_key(), MAX_LANES'($urandom));
      r.item.operation  = mmch_pkg::OP_READ;
      r.item.read_index = idx;
      return r;
   endfunction

   function automatic stim_row_type mk_csr(input logic [SRC_COUNT_BITS-1:0] v);
      stim_row_type r;
      r = '{is_csr: 1'b1, csr_val: v, item: '0, typed: 1'b0, want: '0};
      return r;
   endfunction

   function automatic stim_row_type with_answer(input stim_row_type r,
                                                input mmch_pkg::rsp_type w);
      stim_row_type t;
      t       = r;
      t.typed = 1'b1;
      t.want  = w;
      return t;
   endfunction

   // Present one transaction in a burst/gap pattern, hold it until accepted,
   // then queue its expected response.
   task automatic send_txn(input stim_row_type r, output mmch_pkg::rsp_type pred);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r.item;
      do @(posedge clock); while (req_stall);
      pred = predict_merge(r.item);
      pending_rsp_q.push_back(r.typed ? r.want : pred);
      if (r.item.operation == mmch_pkg::OP_READ) read_count++;
      else if (pred.all_ended) ended_count++;
      else step_count++;
   endtask

   // Stop sending and wait until every queued response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_source_count(input logic [SRC_COUNT_BITS-1:0] v);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en    <= 1'b0;
      src_count_model  = v;
      csr_writes++;
   endtask

   // One well-formed merge: build sorted string-like key lists per lane from a
   // shared pool, then advance lanes by the predicted mask until all end.
   task automatic run_merge(inout int sent);
      logic [FIELD_KEY_BITS-1:0] pool [POOL_DEPTH];
      logic [FIELD_KEY_BITS-1:0] lane_keys [MAX_LANES][POOL_DEPTH];
      logic [FIELD_KEY_BITS-1:0] heads [MAX_LANES];
      logic [MAX_LANES-1:0]      live;
      int                        lane_len [MAX_LANES];
      int                        lane_pos [MAX_LANES];
      int                        nbytes;
      int                        n;
      bit                        done;
      stim_row_type              r;
      mmch_pkg::rsp_type         pred;
      // Leading byte strictly increases, so the pool is already in strcmp order.
      for (int k = 0; k < POOL_DEPTH; k++) begin
         pool[k]        = '0;
         pool[k][63:56] = 8'(8'h30 + 16 * k + $urandom_range(0, 15));
         nbytes         = $urandom_range(0, 7);
         for (int b = 1; b <= nbytes; b++) pool[k][63 - 8 * b -: 8] = 8'($urandom_range(97, 122));
      end
      for (int l = 0; l < MAX_LANES; l++) begin
         lane_len[l] = 0;
         lane_pos[l] = 0;
         if ($urandom_range(0, 7) != 0) begin
            for (int k = 0; k < POOL_DEPTH; k++) begin
               if ($urandom_range(0, 1) == 1) begin
                  lane_keys[l][lane_len[l]] = pool[k];
                  lane_len[l]++;
               end
            end
         end
      end
      n    = lanes_in_use();
      done = 1'b0;
      while (!done) begin
         if ($urandom_range(0, 7) == 0) begin
            send_txn(mk_read(MAX_LANES'($urandom)), pred);
            sent++;
         end
         for (int l = 0; l < MAX_LANES; l++) begin
            if (lane_pos[l] < lane_len[l]) begin
               heads[l] = lane_keys[l][lane_pos[l]];
               live[l]  = 1'b1;
            end else begin
               heads[l] = random_key();
               live[l]  = 1'b0;
            end
            // Lanes beyond the source count carry junk live bits.
            if (l >= n) live[l] = 1'($urandom);
         end
         r = mk_step(heads[0], heads[1], heads[2], heads[3], live);
         send_txn(r, pred);
         sent++;
         if (pred.all_ended) done = 1'b1;
         else begin
            for (int l = 0; l < MAX_LANES; l++) begin
               if (pred.advance_mask[l]) lane_pos[l]++;
            end
         end
      end
   endtask

   // Response side: check each accepted response, then pick the next stall.
   always @(posedge clock) begin
      mmch_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected response: advance_mask %0h count_value %0h all_ended %0b",
                   rsp_data.advance_mask, rsp_data.count_value, rsp_data.all_ended);
            fail_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.advance_mask !== want.advance_mask) begin
               $error("advance_mask: expected %0h, actual %0h",
                      want.advance_mask, rsp_data.advance_mask);
               fail_count++;
            end
            if (rsp_data.count_value !== want.count_value) begin
               $error("count_value: expected %0h, actual %0h",
                      want.count_value, rsp_data.count_value);
               fail_count++;
            end
            if (rsp_data.all_ended !== want.all_ended) begin
               $error("all_ended: expected %0b, actual %0b",
                      want.all_ended, rsp_data.all_ended);
               fail_count++;
            end
         end
      end
      // Stall in segments: none, light, or heavy back-pressure.
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(4, 40);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      endcase
   end

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("multiway_merge_capture_histogram_top verification failed");
      $finish;
   end

   initial begin
      logic [SRC_COUNT_BITS-1:0] phase_counts [$];
      mmch_pkg::rsp_type         pred;
      int                        sent;
      bit                        paused;

      for (int i = 0; i < HIST_DEPTH; i++) mask_count_model[i] = '0;
      src_count_model = mmch_pkg::SRC_COUNT_RESET;

      // Directed table, starting with the two-source reset setting.
      directed_rows.push_back(with_answer(mk_read(4'd0), ZERO_COUNT));
      directed_rows.push_back(with_answer(mk_read(4'd15), ZERO_COUNT));
      directed_rows.push_back(with_answer(mk_step(KEY_MAX, 0, 0, 0, 4'b0000), NONE_LIVE));
      // Only unused lanes live: nothing to count.
      directed_rows.push_back(with_answer(mk_step(KEY_MAX, KEY_MAX, 0, 0, 4'b1100), NONE_LIVE));
      directed_rows.push_back(mk_step(0, KEY_MAX, 0, 0, 4'b1111));
      directed_rows.push_back(mk_step(KEY_MAX, KEY_MAX, 0, 0, 4'b0011));
      directed_rows.push_back(mk_step(KEY_MAX, 0, KEY_MAX, KEY_MAX, 4'b0011));
      directed_rows.push_back(mk_step(KEY_APPLES, KEY_APPLE, 0, 0, 4'b0011));
      directed_rows.push_back(mk_step(0, KEY_MAX, 0, 0, 4'b0010));
      // Source count below range behaves as two.
      directed_rows.push_back(mk_csr(3'd0));
      directed_rows.push_back(mk_step(64'd5, 64'd5, 0, 0, 4'b1111));
      // Source count above range behaves as four.
      directed_rows.push_back(mk_csr(3'd7));
      directed_rows.push_back(mk_step(KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, 4'b1111));
      directed_rows.push_back(mk_step(0, 0, 0, 0, 4'b1111));
      directed_rows.push_back(mk_step(KEY_MAX, KEY_MAX, KEY_MAX, 0, 4'b1000));
      directed_rows.push_back(mk_step(KEY_MAX, KEY_APPLE, 64'd3, 64'd1, 4'b0111));
      directed_rows.push_back(with_answer(mk_step(0, 0, 0, 0, 4'b0000), NONE_LIVE));
      directed_rows.push_back(mk_csr(3'd3));
      directed_rows.push_back(mk_step(KEY_MAX, KEY_MAX, KEY_APPLE, 0, 4'b1111));
      directed_rows.push_back(mk_read(4'd15));
      // Entry zero is never stepped, so it reads back empty.
      directed_rows.push_back(with_answer(mk_read(4'd0), ZERO_COUNT));
      directed_rows.push_back(mk_csr(3'd5));
      directed_rows.push_back(mk_step(64'd1, 64'd2, 64'd3, 64'd0, 4'b1111));
      directed_rows.push_back(mk_read(4'd8));
      directed_rows.push_back(mk_csr(3'd1));
      directed_rows.push_back(mk_step(KEY_APPLE, KEY_APPLE, 0, 0, 4'b1111));
      directed_rows.push_back(mk_read(4'd3));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) write_source_count(directed_rows[i].csr_val);
         else send_txn(directed_rows[i], pred);
      end

      // Random phases covering every source count setting, extremes included.
      phase_counts = '{3'd3, 3'd7, 3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd7};
      foreach (phase_counts[p]) begin
         write_source_count(phase_counts[p]);
         sent   = 0;
         paused = 1'b0;
         while (sent < PHASE_ITEMS) begin
            // Hold off once mid-phase until every response is back.
            if (!paused && sent >= PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
               run_merge(sent);
            end else begin
               if ($urandom_range(0, 1) == 1) begin
                  send_txn(mk_read(MAX_LANES'($urandom)), pred);
               end else begin
                  send_txn(mk_step(random_key(), random_key(), random_key(), random_key(),
                                   MAX_LANES'($urandom)), pred);
               end
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d counted merge steps, %0d steps with no live source, %0d reads",
               step_count, ended_count, read_count);
      $display("across %0d source count writes with random gaps and back-pressure", csr_writes);
      if (fail_count == 0) begin
         $display("multiway_merge_capture_histogram_top verification clean");
      end else begin
         $display("multiway_merge_capture_histogram_top verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/mmch_pkg.sv
hdl/mmch_lane.sv
hdl/mmch_hist.sv
hdl/multiway_merge_capture_histogram_top.sv
tb/tb_top.sv
